// ===== src/gpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared types, constants and the ratio window lookup for the gear estimator.
// ----------------------------------------------------------------------------
package gpe_pkg;

    localparam int SPEED_W = 16;
    localparam int RPM_W   = 8;
    localparam int TICK_W  = 8;
    localparam int RATIO_W = 8;
    localparam int GEAR_W  = 3;
    localparam int PRESS_W = 4;
    localparam int MISS_W  = 3;
    localparam int PHASE_W = 2;
    localparam int DIV_CNT_W = $clog2(SPEED_W);

    localparam logic [GEAR_W-1:0]  GEAR_NONE    = 3'd0;
    localparam logic [GEAR_W-1:0]  GEAR_FIRST   = 3'd1;
    localparam logic [GEAR_W-1:0]  GEAR_SECOND  = 3'd2;
    localparam logic [GEAR_W-1:0]  GEAR_TOP     = 3'd6;
    localparam logic [GEAR_W-1:0]  GEAR_NEUTRAL = 3'd7;

    localparam logic [PRESS_W-1:0] PRESS_MAX   = 4'd11;
    localparam logic [PRESS_W-1:0] PRESS_SHIFT = 4'd2;
    localparam logic [PRESS_W-1:0] PRESS_HELD  = 4'd10;
    localparam logic [PRESS_W-1:0] PRESS_ZERO  = 4'd0;

    localparam logic [MISS_W-1:0]  MISS_ZERO  = 3'd0;
    localparam logic [MISS_W-1:0]  MISS_ONE   = 3'd1;
    localparam logic [MISS_W-1:0]  MISS_TRIP  = 3'd5;
    localparam logic [MISS_W-1:0]  MISS_LIMIT = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [SPEED_W-1:0] vehicle_speed;
        logic [RPM_W-1:0]   engine_speed;
        logic [TICK_W-1:0]  tick_count;
        logic               shift_up_pin;
        logic               shift_down_pin;
        logic               neutral_pin;
    } item_t;

    typedef struct packed {
        logic               start;
        logic [SPEED_W-1:0] dividend;
        logic [RPM_W-1:0]   divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] quotient;
    } div_stat_t;

    // open windows, bounds excluded
    function automatic logic [GEAR_W-1:0] window_of(input logic [RATIO_W-1:0] r);
        logic [GEAR_W-1:0] g;
        g = GEAR_NONE;
        if (r > 8'd48 && r < 8'd53)
            g = 3'd1;
        else if (r > 8'd67 && r < 8'd72)
            g = 3'd2;
        else if (r > 8'd82 && r < 8'd86)
            g = 3'd3;
        else if (r > 8'd93 && r < 8'd97)
            g = 3'd4;
        else if (r > 8'd100 && r < 8'd104)
            g = 3'd5;
        else if (r > 8'd109 && r < 8'd113)
            g = 3'd6;
        return g;
    endfunction

endpackage

// ===== src/gpe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_in_if
// Measurement channel: speeds, tick counter and pin levels.
// ----------------------------------------------------------------------------
interface gpe_in_if;
    logic                         valid;
    logic                         ready;
    logic [gpe_pkg::SPEED_W-1:0]  vehicle_speed;
    logic [gpe_pkg::RPM_W-1:0]    engine_speed;
    logic [gpe_pkg::TICK_W-1:0]   tick_count;
    logic                         shift_up_pin;
    logic                         shift_down_pin;
    logic                         neutral_pin;

    modport source (
        output valid, vehicle_speed, engine_speed, tick_count,
               shift_up_pin, shift_down_pin, neutral_pin,
        input  ready
    );

    modport sink (
        input  valid, vehicle_speed, engine_speed, tick_count,
               shift_up_pin, shift_down_pin, neutral_pin,
        output ready
    );
endinterface

// ===== src/gpe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_out_if
// Result channel: estimated gear.
// ----------------------------------------------------------------------------
interface gpe_out_if;
    logic                        valid;
    logic                        ready;
    logic [gpe_pkg::GEAR_W-1:0]  gear_now;

    modport source (
        output valid, gear_now,
        input  ready
    );

    modport sink (
        input  valid, gear_now,
        output ready
    );
endinterface

// ===== src/gpe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_div
// Bit-serial restoring divider, one quotient bit per cycle, keeps the low
// quotient byte.
// ----------------------------------------------------------------------------
module gpe_div (
    input  logic                clk,
    input  logic                rst_n,
    input  gpe_pkg::div_ctrl_t  ctrl,
    output gpe_pkg::div_stat_t  stat
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [gpe_pkg::DIV_CNT_W-1:0]       cnt_reg, cnt_next;
    logic [gpe_pkg::SPEED_W-1:0]         dvd_reg, dvd_next;
    logic [gpe_pkg::RPM_W-1:0]           dsr_reg, dsr_next;
    logic [gpe_pkg::RPM_W-1:0]           rem_reg, rem_next;
    logic [gpe_pkg::RATIO_W-1:0]         quo_reg, quo_next;
    logic [gpe_pkg::RPM_W:0]             trial;
    logic [gpe_pkg::RPM_W:0]             diff;
    logic                                fits;

    assign trial = {rem_reg, dvd_reg[gpe_pkg::SPEED_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = ctrl.dividend;
            dsr_next  = ctrl.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // below the divisor the trial never needs its top bit
            rem_next = fits ? diff[gpe_pkg::RPM_W-1:0] : trial[gpe_pkg::RPM_W-1:0];
            quo_next = {quo_reg[gpe_pkg::RATIO_W-2:0], fits};
            dvd_next = {dvd_reg[gpe_pkg::SPEED_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// ===== src/gpe_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_update
// Gear tracking state: ratio windows, miss counting, paddle debounce and
// neutral handling, applied once per item on commit.
// ----------------------------------------------------------------------------
module gpe_update (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          commit,
    input  gpe_pkg::item_t                item,
    input  logic [gpe_pkg::RATIO_W-1:0]   quotient,
    output logic [gpe_pkg::GEAR_W-1:0]    gear_next
);

    logic [gpe_pkg::GEAR_W-1:0]   gear_reg;
    logic [gpe_pkg::GEAR_W-1:0]   cand_reg, cand_next;
    logic [gpe_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [gpe_pkg::PRESS_W-1:0]  up_cnt_reg, up_cnt_next;
    logic [gpe_pkg::PRESS_W-1:0]  dn_cnt_reg, dn_cnt_next;
    logic [gpe_pkg::MISS_W-1:0]   miss_reg, miss_next;
    logic [gpe_pkg::PHASE_W-1:0]  tick_lo;
    logic [gpe_pkg::PHASE_W-1:0]  phase_diff;
    logic                         sample;
    logic [gpe_pkg::RATIO_W-1:0]  ratio;
    logic [gpe_pkg::GEAR_W-1:0]   win;
    logic                         hit;
    logic [gpe_pkg::PRESS_W-1:0]  pend;
    logic                         pend_idle;

    assign tick_lo    = item.tick_count[gpe_pkg::PHASE_W-1:0];
    assign phase_diff = tick_lo - phase_reg;
    assign sample     = (phase_diff == '0);
    assign ratio      = (item.engine_speed != '0) ? quotient : '0;
    assign win        = gpe_pkg::window_of(ratio);
    assign hit        = sample && (win != gpe_pkg::GEAR_NONE);

    always_comb
    begin
        gear_next   = gear_reg;
        cand_next   = cand_reg;
        phase_next  = phase_reg;
        up_cnt_next = up_cnt_reg;
        dn_cnt_next = dn_cnt_reg;
        miss_next   = miss_reg;

        if (sample)
        begin
            if (hit)
            begin
                if (cand_reg == win)
                    gear_next = win;
                cand_next = win;
                miss_next = gpe_pkg::MISS_ZERO;
            end
            else
            begin
                if (gear_reg != gpe_pkg::GEAR_NEUTRAL)
                    miss_next = miss_reg + gpe_pkg::MISS_ONE;
                if (miss_next > gpe_pkg::MISS_TRIP)
                begin
                    miss_next = gpe_pkg::MISS_LIMIT;
                    gear_next = gpe_pkg::GEAR_NONE;
                end
                cand_next = gpe_pkg::GEAR_NONE;
            end
        end

        // paddles only act while the ratio matches no window
        if (!hit && gear_next != gpe_pkg::GEAR_NONE)
        begin
            priority if (item.shift_down_pin && !item.shift_up_pin)
            begin
                up_cnt_next = gpe_pkg::PRESS_ZERO;
                if (dn_cnt_reg < gpe_pkg::PRESS_MAX)
                    dn_cnt_next = dn_cnt_reg + 1'b1;
                if (dn_cnt_next == gpe_pkg::PRESS_SHIFT)
                begin
                    phase_next = tick_lo;
                    miss_next  = gpe_pkg::MISS_ZERO;
                    if (gear_next == gpe_pkg::GEAR_NEUTRAL)
                        gear_next = gpe_pkg::GEAR_FIRST;
                    else if (gear_next > gpe_pkg::GEAR_FIRST)
                        gear_next = gear_next - 1'b1;
                end
            end
            else if (item.shift_up_pin && !item.shift_down_pin)
            begin
                dn_cnt_next = gpe_pkg::PRESS_ZERO;
                if (up_cnt_reg < gpe_pkg::PRESS_MAX)
                    up_cnt_next = up_cnt_reg + 1'b1;
                if (up_cnt_next == gpe_pkg::PRESS_SHIFT)
                begin
                    phase_next = tick_lo;
                    miss_next  = gpe_pkg::MISS_ZERO;
                    if (gear_next == gpe_pkg::GEAR_NEUTRAL)
                        gear_next = gpe_pkg::GEAR_SECOND;
                    else if (gear_next < gpe_pkg::GEAR_TOP)
                        gear_next = gear_next + 1'b1;
                end
            end
            else
            begin
                up_cnt_next = gpe_pkg::PRESS_ZERO;
                dn_cnt_next = gpe_pkg::PRESS_ZERO;
            end
        end

        // a press in progress holds off the neutral switch
        pend      = up_cnt_next | dn_cnt_next;
        pend_idle = (pend == gpe_pkg::PRESS_ZERO) || (pend > gpe_pkg::PRESS_HELD);
        if (!item.neutral_pin)
        begin
            if (pend_idle)
            begin
                phase_next = tick_lo;
                gear_next  = gpe_pkg::GEAR_NEUTRAL;
                miss_next  = gpe_pkg::MISS_ZERO;
            end
        end
        else if (gear_next == gpe_pkg::GEAR_NEUTRAL && pend_idle)
        begin
            gear_next = gpe_pkg::GEAR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_reg   <= gpe_pkg::GEAR_NONE;
            cand_reg   <= gpe_pkg::GEAR_NONE;
            phase_reg  <= '0;
            up_cnt_reg <= gpe_pkg::PRESS_ZERO;
            dn_cnt_reg <= gpe_pkg::PRESS_ZERO;
            miss_reg   <= gpe_pkg::MISS_ZERO;
        end
        else if (commit)
        begin
            gear_reg   <= gear_next;
            cand_reg   <= cand_next;
            phase_reg  <= phase_next;
            up_cnt_reg <= up_cnt_next;
            dn_cnt_reg <= dn_cnt_next;
            miss_reg   <= miss_next;
        end
    end

endmodule

// ===== src/gear_position_estimator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear_position_estimator
// Estimates the engaged gear from the speed/rpm ratio, paddle pins and the
// neutral switch.
// ----------------------------------------------------------------------------
//  channel  role    payload
//  meas     sink    vehicle_speed, engine_speed, tick_count, pins
//  gear     source  gear_now
//
// an item passes from transfer to result through the bit-serial divider
// (one quotient bit per cycle), the divider's registered done flag, and the
// commit state, which updates the gear state and loads the output register.
// the next item is taken in the cycle after that, and not before, while the
// result may still wait in its register.
// a result that is not taken holds the following item before its commit.
// reset clears all gear tracking state to zero.
// ----------------------------------------------------------------------------
module gear_position_estimator (
    input  logic         clk,
    input  logic         rst_n,
    gpe_in_if.sink       meas,
    gpe_out_if.source    gear
);

    gpe_pkg::state_t                 state_reg, state_next;
    gpe_pkg::item_t                  item_reg, item_next;
    gpe_pkg::div_ctrl_t              div_ctrl;
    gpe_pkg::div_stat_t              div_stat;
    logic                            out_valid_reg, out_valid_next;
    logic [gpe_pkg::GEAR_W-1:0]      out_gear_reg, out_gear_next;
    logic [gpe_pkg::GEAR_W-1:0]      gear_upd;
    logic                            commit;
    logic                            take;

    assign take = meas.valid && meas.ready;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        meas.ready     = 1'b0;
        commit         = 1'b0;
        out_valid_next = out_valid_reg;
        out_gear_next  = out_gear_reg;

        if (gear.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            gpe_pkg::ST_IDLE:
            begin
                meas.ready = 1'b1;
                if (meas.valid)
                begin
                    item_next.vehicle_speed  = meas.vehicle_speed;
                    item_next.engine_speed   = meas.engine_speed;
                    item_next.tick_count     = meas.tick_count;
                    item_next.shift_up_pin   = meas.shift_up_pin;
                    item_next.shift_down_pin = meas.shift_down_pin;
                    item_next.neutral_pin    = meas.neutral_pin;
                    state_next = gpe_pkg::ST_DIV;
                end
            end
            gpe_pkg::ST_DIV:
            begin
                if (div_stat.done)
                    state_next = gpe_pkg::ST_COMMIT;
            end
            gpe_pkg::ST_COMMIT:
            begin
                // output slot free or being emptied this cycle
                if (!out_valid_reg || gear.ready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    out_gear_next  = gear_upd;
                    state_next     = gpe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gpe_pkg::ST_IDLE;
            end
        endcase
    end

    assign div_ctrl.start    = take;
    assign div_ctrl.dividend = meas.vehicle_speed;
    assign div_ctrl.divisor  = meas.engine_speed;

    gpe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    gpe_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .item      (item_reg),
        .quotient  (div_stat.quotient),
        .gear_next (gear_upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gpe_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_gear_reg <= out_gear_next;
    end

    assign gear.valid    = out_valid_reg;
    assign gear.gear_now = out_gear_reg;

endmodule
